@@ hw/rtl/ffha_pkg.sv @@
package ffha_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int PAGE_SHIFT   = 12;
    localparam int MAX_PAGES    = 256;
    localparam int PAGE_W       = 9;
    localparam int HEADER_BYTES = 16;
    localparam int PAD_BYTES    = 'h10;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ZERO    = 3'd1;
    localparam logic [2:0] ST_OOM     = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;

    typedef struct packed {
        logic [19:0] offset;
        logic [19:0] size;
    } entry_t;

endpackage

@@ hw/rtl/ffha_table.sv @@
module ffha_table (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [ffha_pkg::IDX_W-1:0] wr_idx,
    input  ffha_pkg::entry_t      wr_data,
    input  logic [ffha_pkg::IDX_W-1:0] rd_idx,
    output ffha_pkg::entry_t      rd_data
);
    import ffha_pkg::*;

    entry_t mem [MAX_BLOCKS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        rd_data <= mem[rd_idx];
    end
endmodule

@@ hw/rtl/first_fit_heap_allocator_core.sv @@
// First-fit heap allocator. Each transfer on s_axis is an allocate or a free;
// each produces exactly one transfer on m_axis. The block table (offset and
// size) lives in a synchronous RAM that is read one entry per cycle, so an
// allocate or free walks the table entry by entry through the single RAM read
// port until it finds a match or runs out of entries.
// The input is held off until the result transfer completes, so the block
// takes no new request before it is through with the last one; a zero-size
// allocate is answered without a walk. Taken flags sit in flip-flops cleared
// at reset. heap_base is to be written through cfg_wr_en and cfg_wr_data only
// while no request is in flight; the block itself does not enforce this.
module first_fit_heap_allocator_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [47:0]  cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [0] operation, [20:1] request_size, [68:21] free_address, rest zero
    input  logic [71:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [47:0] payload_address, [50:48] result_status, [82:51] bytes_used,
    // [91:83] heap_pages_now, rest zero
    output logic [95:0]  m_axis_tdata
);
    import ffha_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [47:0]       heap_base_reg;
    logic              op_reg;
    logic [19:0]       size_reg;
    logic [47:0]       addr_reg;
    logic [CNT_W-1:0]  rd_cnt_reg;      // next index to request
    logic [CNT_W-1:0]  chk_cnt_reg;     // index whose data is on rd_data
    logic              chk_vld_reg;
    logic [MAX_BLOCKS-1:0] taken_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [20:0]       bump_reg;
    logic [PAGE_W-1:0] pages_reg;
    logic [31:0]       used_reg;
    logic              out_vld_reg;
    logic [47:0]       out_addr_reg;
    logic [2:0]        out_st_reg;

    entry_t            rd_data;
    entry_t            wr_data;
    logic              wr_en;
    logic [IDX_W-1:0]  chk_idx;
    logic [47:0]       chk_payload;
    logic              hit;
    logic [21:0]       need;
    logic [10:0]       pages_needed;

    assign s_axis_tready = (state_reg == S_IDLE) && !out_vld_reg;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {4'd0, pages_reg, used_reg, out_st_reg, out_addr_reg};

    assign chk_idx     = chk_cnt_reg[IDX_W-1:0];
    assign chk_payload = heap_base_reg + {28'd0, rd_data.offset} + 48'(HEADER_BYTES);
    assign hit = chk_vld_reg && ((op_reg == OP_ALLOC)
               ? (!taken_reg[chk_idx] && rd_data.size >= size_reg)
               : (chk_payload == addr_reg));
    assign need = {1'b0, bump_reg} + {2'd0, size_reg} + 22'(HEADER_BYTES);
    assign pages_needed = 11'(need >> PAGE_SHIFT) + 11'd1;

    assign wr_data.offset = bump_reg[19:0];
    assign wr_data.size   = size_reg;
    assign wr_en = (state_reg == S_DONE) && (op_reg == OP_ALLOC)
                && (count_reg != CNT_W'(MAX_BLOCKS)) && (pages_needed <= 11'(MAX_PAGES));

    ffha_table u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_idx  (count_reg[IDX_W-1:0]),
        .wr_data (wr_data),
        .rd_idx  (rd_cnt_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                // A zero-size allocate is answered at once and needs no walk.
                if (!(s_axis_tdata[0] == OP_ALLOC && s_axis_tdata[20:1] == 20'd0)) begin
                    state_next = S_WALK;
                end
            end
            S_WALK: if (hit || (!chk_vld_reg && rd_cnt_reg >= count_reg)) begin
                state_next = hit ? S_IDLE : S_DONE;
            end
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            heap_base_reg <= '0;
            taken_reg     <= '0;
            count_reg     <= '0;
            bump_reg      <= '0;
            pages_reg     <= PAGE_W'(1);
            used_reg      <= '0;
            out_vld_reg   <= 1'b0;
            chk_vld_reg   <= 1'b0;
            rd_cnt_reg    <= '0;
            chk_cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                heap_base_reg <= cfg_wr_data;
            end
            if (out_vld_reg && m_axis_tready) begin
                out_vld_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    chk_vld_reg <= 1'b0;
                    rd_cnt_reg  <= '0;
                    if (s_axis_tvalid && s_axis_tready) begin
                        op_reg   <= s_axis_tdata[0];
                        size_reg <= s_axis_tdata[20:1];
                        addr_reg <= s_axis_tdata[68:21];
                        if (s_axis_tdata[0] == OP_ALLOC && s_axis_tdata[20:1] == 20'd0) begin
                            out_vld_reg  <= 1'b1;
                            out_addr_reg <= '0;
                            out_st_reg   <= ST_ZERO;
                        end
                    end
                end
                S_WALK: begin
                    if (hit) begin
                        out_vld_reg <= 1'b1;
                        chk_vld_reg <= 1'b0;
                        if (op_reg == OP_ALLOC) begin
                            taken_reg[chk_idx] <= 1'b1;
                            used_reg     <= used_reg + 32'(size_reg) + 32'(HEADER_BYTES + PAD_BYTES);
                            out_addr_reg <= chk_payload;
                            out_st_reg   <= ST_OK;
                        end else begin
                            out_addr_reg <= '0;
                            if (taken_reg[chk_idx]) begin
                                taken_reg[chk_idx] <= 1'b0;
                                used_reg   <= used_reg - 32'(rd_data.size) - 32'(HEADER_BYTES);
                                out_st_reg <= ST_OK;
                            end else begin
                                out_st_reg <= ST_UNKNOWN;
                            end
                        end
                    end else begin
                        chk_vld_reg <= rd_cnt_reg < count_reg;
                        chk_cnt_reg <= rd_cnt_reg;
                        if (rd_cnt_reg < count_reg) begin
                            rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
                        end
                    end
                end
                S_DONE: begin
                    out_vld_reg  <= 1'b1;
                    out_addr_reg <= '0;
                    if (op_reg == OP_FREE) begin
                        out_st_reg <= ST_UNKNOWN;
                    end else if (count_reg == CNT_W'(MAX_BLOCKS)) begin
                        out_st_reg <= ST_FULL;
                    end else if (pages_needed > 11'(MAX_PAGES)) begin
                        out_st_reg <= ST_OOM;
                    end else begin
                        out_st_reg <= ST_OK;
                        out_addr_reg <= heap_base_reg + {27'd0, bump_reg} + 48'(HEADER_BYTES);
                        if (pages_needed > 11'(pages_reg)) begin
                            pages_reg <= pages_needed[PAGE_W-1:0];
                        end
                        taken_reg[count_reg[IDX_W-1:0]] <= 1'b1;
                        count_reg <= count_reg + CNT_W'(1);
                        bump_reg  <= bump_reg + 21'(size_reg) + 21'(HEADER_BYTES + PAD_BYTES);
                        used_reg  <= used_reg + 32'(size_reg) + 32'(HEADER_BYTES + PAD_BYTES);
                    end
                end
                default: ;
            endcase
        end
    end

    a_one_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> state_reg == S_IDLE)
        else $error("result pending while a walk runs");
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("entry count over table depth");
    a_pages_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        pages_reg >= $past(pages_reg) && pages_reg != '0)
        else $error("page count shrank");
endmodule
